FILE: sv/gaussian_blur_3x3_unit_defines.svh
// Assertion helpers for the blur filter core
`ifndef GAUSSIAN_BLUR_3X3_UNIT_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GB3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GB3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gb3_pkg.sv
package gb3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int OWED_W     = COL_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Transaction command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [FW_W-1:0]  width_t;
  typedef logic [FH_W-1:0]  row_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One line-store entry: rows two and one above the incoming row
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_word_t;

  typedef struct packed {
    logic       en;
    col_t       addr;
    line_word_t data;
  } line_wr_t;

  // Accepted input transaction, as handed to the filter core
  typedef struct packed {
    logic   take;
    logic   cmd;
    col_t   col;
    pixel_t px;
  } in_item_t;

endpackage

FILE: sv/gb3_stream_if.sv
interface gb3_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, command, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, command, blue_in, green_in, red_in, output ready);
endinterface

interface gb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_last;

  modport source (output valid, blue_out, green_out, red_out, frame_last, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, frame_last, output ready);
endinterface

FILE: sv/gb3_line_store.sv
module gb3_line_store (
  input  logic               clk,
  input  logic               rd_en,
  input  gb3_pkg::col_t      rd_addr,
  input  gb3_pkg::line_wr_t  wr,
  output gb3_pkg::line_word_t rd_data
);
  import gb3_pkg::*;

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_data_r;

  // Write one entry, read one entry; bypass the write on an address match
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/gb3_filter_core.sv
`include "gaussian_blur_3x3_unit_defines.svh"

module gb3_filter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gb3_pkg::in_item_t    item,
  input  gb3_pkg::line_word_t  rd_data,
  input  gb3_pkg::width_t      w_used,
  input  gb3_pkg::row_t        h_used,
  output logic                 s1_ready,
  output gb3_pkg::line_wr_t    wr,
  gb3_out_if.source            out
);
  import gb3_pkg::*;

  // 1-2-1 kernel on one channel: columns a (older), b, c (newest)
  function automatic logic [7:0] blur_chan(
    input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
    input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2
  );
    logic [11:0] s;
    s = 12'(a0) + (12'(a1) << 1) + 12'(a2)
      + (12'(b0) << 1) + (12'(b1) << 2) + (12'(b2) << 1)
      + 12'(c0) + (12'(c1) << 1) + 12'(c2);
    return s[11:4];
  endfunction

  logic              s1_valid_r;
  logic              s1_cmd_r;
  col_t              s1_col_r;
  pixel_t            s1_px_r;

  pixel_t            win_r [6];
  pixel_t            win_nxt [6];
  logic [OWED_W-1:0] owed_r, owed_nxt;
  col_t              ocol_r, ocol_nxt;
  row_t              orow_r, orow_nxt;

  logic              out_valid_r, out_valid_nxt;
  pixel_t            out_px_r, out_px_nxt;
  logic              out_last_r, out_last_nxt;

  logic              adv;
  logic              is_pix;
  logic              col_end;
  logic              row_end;
  logic              last;
  logic              border;
  logic              owed_full;
  logic              emit_pix;
  pixel_t            col_top, col_mid;
  pixel_t            blur_px;

  assign adv      = s1_valid_r && (!out_valid_r || out.ready);
  assign s1_ready = rst_n && (!s1_valid_r || adv);
  assign is_pix   = (s1_cmd_r == CMD_PIXEL);

  // Capture the accepted transaction alongside the line-store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= item.take;
    end
  end

  always_ff @(posedge clk) begin
    if (item.take) begin
      s1_cmd_r <= item.cmd;
      s1_col_r <= item.col;
      s1_px_r  <= item.px;
    end
  end

  // Output position and window geometry
  assign col_end   = ({1'b0, ocol_r} + 12'd1) >= w_used;
  assign row_end   = ({1'b0, orow_r} + 17'd1) >= {1'b0, h_used};
  assign last      = col_end && row_end;
  assign border    = (orow_r == '0) || row_end || (ocol_r == '0) || col_end;
  assign owed_full = {1'b0, owed_r} >= ({1'b0, w_used} + 13'd1);
  assign emit_pix  = is_pix && owed_full;

  assign col_top = rd_data.upper;
  assign col_mid = rd_data.middle;

  always_comb begin
    blur_px.blue  = blur_chan(win_r[0].blue,  win_r[1].blue,  win_r[2].blue,
                              win_r[3].blue,  win_r[4].blue,  win_r[5].blue,
                              col_top.blue,   col_mid.blue,   s1_px_r.blue);
    blur_px.green = blur_chan(win_r[0].green, win_r[1].green, win_r[2].green,
                              win_r[3].green, win_r[4].green, win_r[5].green,
                              col_top.green,  col_mid.green,  s1_px_r.green);
    blur_px.red   = blur_chan(win_r[0].red,   win_r[1].red,   win_r[2].red,
                              win_r[3].red,   win_r[4].red,   win_r[5].red,
                              col_top.red,    col_mid.red,    s1_px_r.red);
  end

  // Shift the line stores: old middle moves up, the new pixel becomes middle
  assign wr.en          = adv && is_pix;
  assign wr.addr        = s1_col_r;
  assign wr.data.upper  = col_mid;
  assign wr.data.middle = s1_px_r;

  // Advance window, counters and the result register
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = win_r[i];
    end
    owed_nxt      = owed_r;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    out_valid_nxt = out_valid_r && !out.ready;
    out_px_nxt    = out_px_r;
    out_last_nxt  = out_last_r;

    if (adv) begin
      out_valid_nxt = 1'b0;
      if (is_pix) begin
        win_nxt[0] = win_r[3];
        win_nxt[1] = win_r[4];
        win_nxt[2] = win_r[5];
        win_nxt[3] = col_top;
        win_nxt[4] = col_mid;
        win_nxt[5] = s1_px_r;
        if (!owed_full) begin
          owed_nxt = owed_r + 1'b1;
        end
      end else if (owed_r != '0) begin
        owed_nxt = owed_r - 1'b1;
      end

      if (emit_pix || (!is_pix && (owed_r != '0))) begin
        out_valid_nxt = 1'b1;
        out_px_nxt    = (emit_pix && !border) ? blur_px : '0;
        out_last_nxt  = last;
        if (col_end) begin
          ocol_nxt = '0;
          orow_nxt = row_end ? '0 : orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      owed_r      <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_nxt[i];
      end
      owed_r      <= owed_nxt;
      ocol_r      <= ocol_nxt;
      orow_r      <= orow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_px_r   <= out_px_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out.valid      = out_valid_r;
  assign out.blue_out   = out_px_r.blue;
  assign out.green_out  = out_px_r.green;
  assign out.red_out    = out_px_r.red;
  assign out.frame_last = out_last_r;

  // Stall only when both the work stage and the result register are full
  `GB3_ASSERT_IMP(a_stall_cause, !s1_ready, s1_valid_r && out_valid_r && !out.ready,
    "input stalled without a full pipeline")
  // Line stores are written only by an advancing pixel transaction
  `GB3_ASSERT_IMP(a_wr_gate, wr.en, s1_valid_r && (s1_cmd_r == CMD_PIXEL),
    "line store written outside a pixel transaction")
  // Border positions come out black
  `GB3_ASSERT_NXT(a_border_zero, adv && emit_pix && border,
    out.valid && (out.blue_out == 8'd0) && (out.green_out == 8'd0) && (out.red_out == 8'd0),
    "border pixel not zero")
  // A flush with nothing owed produces no result
  `GB3_ASSERT_NXT(a_flush_empty, adv && !is_pix && (owed_r == '0), !out.valid,
    "result produced by an empty flush")

endmodule

FILE: sv/gaussian_blur_3x3_unit.sv
// Channel   Direction  Handshake      Payload
// in_px     sink       valid/ready    command, blue_in, green_in, red_in
// out_px    source     valid/ready    blue_out, green_out, red_out, frame_last
// cfg       write      cfg_we         cfg_index, cfg_data (frame_width, frame_height)
//
// One transaction per clock unless stalled: line-store read at accept, then kernel and
// result register once the work stage advances.
// A pixel result lags its input by frame_width + 1 pixel transactions.
// Synchronous active-low reset clears control state; the line stores are not cleared.
// The input stalls only while reset is held, or while a result waits in the output
// register and the work stage is full; the output register decouples the two sides.
module gaussian_blur_3x3_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  gb3_in_if.sink                        in_px,
  gb3_out_if.source                     out_px,
  input  logic                          cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gb3_pkg::*;

  width_t     frame_width_r;
  row_t       frame_height_r;
  width_t     w_used;
  row_t       h_used;
  col_t       in_col_r, in_col_nxt;
  logic       s1_ready;
  logic       take;
  in_item_t   item;
  line_wr_t   wr;
  line_word_t rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the usable range
  always_comb begin
    if (frame_width_r == '0) begin
      w_used = width_t'(1);
    end else if (frame_width_r > width_t'(MAX_WIDTH)) begin
      w_used = width_t'(MAX_WIDTH);
    end else begin
      w_used = frame_width_r;
    end
    h_used = (frame_height_r == '0) ? row_t'(1) : frame_height_r;
  end

  assign in_px.ready = s1_ready;
  assign take        = in_px.valid && s1_ready;

  // Advance the input column on each accepted pixel
  always_comb begin
    in_col_nxt = in_col_r;
    if (take && (in_px.command == CMD_PIXEL)) begin
      if (({1'b0, in_col_r} + 12'd1) >= w_used) begin
        in_col_nxt = '0;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
    end else begin
      in_col_r <= in_col_nxt;
    end
  end

  assign item.take     = take;
  assign item.cmd      = in_px.command;
  assign item.col      = in_col_r;
  assign item.px.red   = in_px.red_in;
  assign item.px.green = in_px.green_in;
  assign item.px.blue  = in_px.blue_in;

  gb3_line_store u_line_store (
    .clk     (clk),
    .rd_en   (take && (in_px.command == CMD_PIXEL)),
    .rd_addr (in_col_r),
    .wr      (wr),
    .rd_data (rd_data)
  );

  gb3_filter_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .rd_data  (rd_data),
    .w_used   (w_used),
    .h_used   (h_used),
    .s1_ready (s1_ready),
    .wr       (wr),
    .out      (out_px)
  );

endmodule

FILE: sim/gaussian_blur_3x3_unit_test.sv
`timescale 1ns / 1ps

module gaussian_blur_3x3_unit_test;
  import gb3_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1000;
  localparam int unsigned WIDE_PIXELS   = 160;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  // One column of the 3x3 neighborhood, rows top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } blurred_px_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gb3_in_if  in_px ();
  gb3_out_if out_px ();

  gaussian_blur_3x3_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Blur predictor state
  width_t      cfg_width;
  row_t        cfg_height;
  pixel_t      upper_store [MAX_WIDTH];
  pixel_t      middle_store [MAX_WIDTH];
  column_t     older_col;
  column_t     newer_col;
  int unsigned in_col_pos;
  int unsigned in_row_pos;
  int unsigned out_col_pos;
  int unsigned out_row_pos;
  int unsigned owed_count;
  blurred_px_t expected_blurred [$];

  int unsigned failures;
  int unsigned burst_left;
  bit          sender_idles;
  int unsigned hold_requests;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 1-2-1 / 2-4-2 / 1-2-1 per channel, divided by 16 with truncation
  function automatic pixel_t blur_kernel(input column_t older, input column_t newer,
                                         input column_t fresh);
    pixel_t      res;
    int unsigned acc;
    int          ch;
    for (ch = 0; ch < 3; ch++) begin
      acc = older.top[8*ch +: 8] + 2 * newer.top[8*ch +: 8] + fresh.top[8*ch +: 8]
          + 2 * older.mid[8*ch +: 8] + 4 * newer.mid[8*ch +: 8] + 2 * fresh.mid[8*ch +: 8]
          + older.bot[8*ch +: 8] + 2 * newer.bot[8*ch +: 8] + fresh.bot[8*ch +: 8];
      res[8*ch +: 8] = 8'(acc >> 4);
    end
    return res;
  endfunction

  // Advance a raster position, wrapping column then row
  task automatic step_position(inout int unsigned col, inout int unsigned row,
                               input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  // Update the predictor with one accepted transaction
  task automatic predict_blur(input logic cmd, input pixel_t px);
    int unsigned w;
    int unsigned h;
    logic        last;
    logic        border;
    pixel_t      col_top;
    pixel_t      col_mid;
    pixel_t      res;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    last = (out_row_pos + 1 >= h) && (out_col_pos + 1 >= w);
    if (cmd == CMD_FLUSH) begin
      // flush emits a zero pixel only while outputs are owed
      if (owed_count != 0) begin
        expected_blurred.push_back('{blue: 8'd0, green: 8'd0, red: 8'd0, last: last});
        step_position(out_col_pos, out_row_pos, w, h);
        owed_count--;
      end
    end else begin
      col_top = upper_store[in_col_pos];
      col_mid = middle_store[in_col_pos];
      upper_store[in_col_pos]  = col_mid;
      middle_store[in_col_pos] = px;
      owed_count++;
      if (owed_count > w + 1) begin
        border = out_row_pos == 0 || out_row_pos + 1 >= h
              || out_col_pos == 0 || out_col_pos + 1 >= w;
        res = border ? '0 : blur_kernel(older_col, newer_col, {col_top, col_mid, px});
        expected_blurred.push_back('{blue: res.blue, green: res.green, red: res.red,
                                     last: last});
        step_position(out_col_pos, out_row_pos, w, h);
        owed_count--;
      end
      older_col = newer_col;
      newer_col = {col_top, col_mid, px};
      step_position(in_col_pos, in_row_pos, w, h);
    end
  endtask

  function automatic pixel_t pick_pixel(input bit extremes);
    pixel_t px;
    px = pixel_t'($urandom);
    if (extremes) begin
      px.red   = {8{px.red[0]}};
      px.green = {8{px.green[0]}};
      px.blue  = {8{px.blue[0]}};
    end
    return px;
  endfunction

  // Offer one transaction in bursts, with random gaps while sender_idles is set; predict on accept
  task automatic send_item(input logic cmd, input pixel_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_px.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_px.valid    = 1'b1;
    in_px.command  = cmd;
    in_px.blue_in  = px.blue;
    in_px.green_in = px.green;
    in_px.red_in   = px.red;
    do @(posedge clk); while (!in_px.ready);
    predict_blur(cmd, px);
  endtask

  // Drop valid and hold until every predicted result is back
  task automatic drain_results();
    int unsigned waited;
    @(negedge clk);
    in_px.valid = 1'b0;
    waited = 0;
    while (expected_blurred.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_blurred.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_blurred.size());
      failures += expected_blurred.size();
      expected_blurred.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = value[FW_W-1:0];
    else cfg_height = value[FH_W-1:0];
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data);
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
  endtask

  // Stream pixels with occasional stray flushes and mid-frame pauses
  task automatic send_pixels(input int unsigned count, input int unsigned noise_pct,
                             input bit extremes);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(CMD_FLUSH, pick_pixel(1'b0));
      if ($urandom_range(0, 99) == 0) drain_results();
      send_item(CMD_PIXEL, pick_pixel(extremes));
    end
  endtask

  // Flush out every owed output, add spare flushes, then go idle
  task automatic finish_frame(input int unsigned extra);
    while (owed_count != 0) send_item(CMD_FLUSH, pick_pixel(1'b0));
    repeat (extra) send_item(CMD_FLUSH, pick_pixel(1'b0));
    drain_results();
  endtask

  // Small frame: saturated window, zero pixel, distinct channels
  task automatic test_directed_frame();
    int unsigned i;
    pixel_t      px;
    sender_idles = 1'b1;
    set_frame(16'd4, 16'd4);
    send_item(CMD_FLUSH, 24'hFFFFFF);
    for (i = 0; i < 16; i++) begin
      if (i < 11) px = 24'hFFFFFF;
      else if (i == 11) px = '0;
      else px = {8'(17 * i), 8'(255 - 13 * i), 8'(5 * i)};
      send_item(CMD_PIXEL, px);
    end
    finish_frame(1);
  endtask

  // Zero registers, single rows and columns, smallest interior
  task automatic test_degenerate_sizes();
    set_frame(16'd0, 16'd0);
    send_pixels(5, 0, 1'b0);
    finish_frame(1);
    set_frame(16'd1, 16'd5);
    send_pixels(10, 0, 1'b1);
    finish_frame(0);
    set_frame(16'd7, 16'd1);
    send_pixels(14, 0, 1'b0);
    finish_frame(1);
    set_frame(16'd3, 16'd3);
    send_pixels(18, 0, 1'b0);
    finish_frame(0);
  endtask

  // Width register above the limit clamps to the widest line, so a partial
  // row stays owed; a narrow width then closes the row at its next pixel
  task automatic test_max_width_row();
    sender_idles = 1'b0;
    set_frame(16'h0FFF, 16'd1);
    send_pixels(WIDE_PIXELS, 0, 1'b0);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 16'(WIDE_PIXELS + 1));
    send_pixels(1, 0, 1'b0);
    finish_frame(0);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned phase_no;
    int unsigned w;
    int unsigned h;
    int unsigned area;
    int unsigned frames;
    bit          extremes;
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 19))
        0:       w = 0;
        1, 2:    w = $urandom_range(13, 64);
        default: w = $urandom_range(1, 12);
      endcase
      h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      frames = (area > 200) ? 1 : $urandom_range(1, 3);
      sender_idles = ($urandom_range(0, 3) != 0);
      extremes = ($urandom_range(0, 9) == 0);
      // the upper data bits fall outside the width register
      set_frame({4'($urandom_range(0, 15)), 12'(w)}, 16'(h));
      if (phase_no % 4 == 0) hold_requests++;
      send_pixels(area * frames, 4, extremes);
      finish_frame($urandom_range(0, 2));
      sent += area * frames;
      phase_no++;
    end
  endtask

  // Tallest frame register; must run last since it ends mid-frame
  task automatic test_tall_frame();
    sender_idles = 1'b1;
    set_frame(16'd3, 16'hFFFF);
    send_pixels(150, 4, 1'b0);
    finish_frame(1);
  endtask

  // Receiver: ready pattern in modes, plus long hold-offs on request
  initial begin : result_ready_pattern
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_granted;
    out_px.ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_granted = 0;
    forever begin
      @(negedge clk);
      if (holds_granted != hold_requests) begin
        holds_granted = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_px.ready = 1'b0;
      end else begin
        case (mode)
          0:       out_px.ready = 1'b1;
          1:       out_px.ready = $urandom_range(0, 1);
          2:       out_px.ready = ($urandom_range(0, 3) == 0);
          default: out_px.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    blurred_px_t want;
    if (rst_n && out_px.valid && out_px.ready) begin
      if (expected_blurred.size() == 0) begin
        $display("%0t: unexpected result b=%0d g=%0d r=%0d last=%0b", $time,
                 out_px.blue_out, out_px.green_out, out_px.red_out, out_px.frame_last);
        failures++;
      end else begin
        want = expected_blurred.pop_front();
        if (out_px.blue_out !== want.blue) begin
          $display("%0t: blue_out expected %0d, got %0d", $time, want.blue,
                   out_px.blue_out);
          failures++;
        end
        if (out_px.green_out !== want.green) begin
          $display("%0t: green_out expected %0d, got %0d", $time, want.green,
                   out_px.green_out);
          failures++;
        end
        if (out_px.red_out !== want.red) begin
          $display("%0t: red_out expected %0d, got %0d", $time, want.red,
                   out_px.red_out);
          failures++;
        end
        if (out_px.frame_last !== want.last) begin
          $display("%0t: frame_last expected %0b, got %0b", $time, want.last,
                   out_px.frame_last);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("gaussian_blur_3x3_unit_test failed");
    $finish;
  end

  initial begin : run_tests
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_px.valid    = 1'b0;
    in_px.command  = CMD_PIXEL;
    in_px.blue_in  = '0;
    in_px.green_in = '0;
    in_px.red_in   = '0;
    cfg_width      = FRAME_WIDTH_RST;
    cfg_height     = FRAME_HEIGHT_RST;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_store[i]  = '0;
      middle_store[i] = '0;
    end
    older_col     = '0;
    newer_col     = '0;
    in_col_pos    = 0;
    in_row_pos    = 0;
    out_col_pos   = 0;
    out_row_pos   = 0;
    owed_count    = 0;
    failures      = 0;
    burst_left    = 0;
    sender_idles  = 1'b1;
    hold_requests = 0;

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frame();
    test_degenerate_sizes();
    test_max_width_row();
    test_random_frames();
    test_tall_frame();
    drain_results();

    if (failures == 0) begin
      $display("gaussian_blur_3x3_unit_test passed");
    end else begin
      $display("gaussian_blur_3x3_unit_test failed");
    end
    $finish;
  end

endmodule
